// File: rtl/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants for the paged frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int MAX_FRAMES_DEF         = 256;
    localparam int MAX_SLOTS_DEF          = 8;
    localparam int MAX_PAGES_PER_SLOT_DEF = 64;
    localparam int TLB_ENTRIES_DEF        = 8;

    localparam logic [1:0] OP_SETUP  = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_TERM   = 2'd2;
    localparam logic [1:0] OP_ACCESS = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOMEM = 2'd1;
    localparam logic [1:0] ST_TRAP  = 2'd2;
    localparam logic [1:0] ST_BUSY  = 2'd3;

    localparam logic [1:0] CFG_PAGE_BITS  = 2'd0;
    localparam logic [1:0] CFG_FRAME_BITS = 2'd1;
    localparam logic [1:0] CFG_TLB_SIZE   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  slot;
        logic [31:0] operand_value;
    } pfa_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        tlb_hit;
        logic [7:0]  frame_number;
        logic [15:0] page_offset;
        logic [6:0]  pages_granted;
        logic [15:0] waste_bytes;
        logic [8:0]  frames_free;
    } pfa_out_t;

    typedef struct packed {
        logic       start;
        logic       setup;
        logic [7:0] frame;
    } pfa_tlb_req_t;

    typedef struct packed {
        logic       done;
        logic       hit;
    } pfa_tlb_rsp_t;

endpackage

// File: rtl/pfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/pfa_tlb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_tlb
// true-lru tlb, one entry compared per cycle by a shared comparator
// ----------------------------------------------------------------------------
module pfa_tlb
    import pfa_pkg::*;
#(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [$clog2(TLB_ENTRIES+1)-1:0] tlb_n,
    input  pfa_tlb_req_t                   req,
    output pfa_tlb_rsp_t                   rsp
);
    localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int CW = $clog2(TLB_ENTRIES + 1);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_SCAN = 2'd1;
    localparam logic [1:0] T_AGE  = 2'd2;

    logic [7:0]    frm_reg [TLB_ENTRIES];
    logic [IW-1:0] rank_reg [TLB_ENTRIES];
    logic [1:0]    st_reg, st_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] ent_reg, ent_next;
    logic          hit_reg, hit_next;
    logic          lru_ok_reg, lru_ok_next;
    logic [IW-1:0] lru_reg, lru_next;
    logic [IW-1:0] vrank_reg, vrank_next;
    logic [IW-1:0] cur;
    logic [IW-1:0] top;
    logic          last;

    assign cur  = idx_reg[IW-1:0];
    assign top  = IW'(tlb_n - CW'(1));
    assign last = (idx_reg == tlb_n - CW'(1));

    always_comb
    begin
        st_next     = st_reg;
        idx_next    = idx_reg;
        ent_next    = ent_reg;
        hit_next    = hit_reg;
        lru_ok_next = lru_ok_reg;
        lru_next    = lru_reg;
        vrank_next  = vrank_reg;
        rsp.done    = 1'b0;
        rsp.hit     = hit_reg;
        unique case (st_reg)
            T_IDLE:
            begin
                if (req.start)
                begin
                    st_next     = T_SCAN;
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    lru_ok_next = 1'b0;
                    lru_next    = '0;
                end
            end
            T_SCAN:
            begin
                if (!hit_reg && frm_reg[cur] == req.frame)
                begin
                    hit_next = 1'b1;
                    ent_next = cur;
                end
                if (!lru_ok_reg && rank_reg[cur] == '0)
                begin
                    lru_ok_next = 1'b1;
                    lru_next    = cur;
                end
                if (last)
                begin
                    st_next    = T_AGE;
                    idx_next   = '0;
                    vrank_next = hit_next ? rank_reg[ent_next]
                                          : (lru_ok_next ? '0 : rank_reg[0]);
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            T_AGE:
            begin
                if (last)
                begin
                    st_next  = T_IDLE;
                    rsp.done = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            default:
            begin
                st_next = T_IDLE;
            end
        endcase
    end

    logic [IW-1:0] victim;
    assign victim = hit_reg ? ent_reg : (lru_ok_reg ? lru_reg : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= T_IDLE;
            idx_reg    <= '0;
            ent_reg    <= '0;
            hit_reg    <= 1'b0;
            lru_ok_reg <= 1'b0;
            lru_reg    <= '0;
            vrank_reg  <= '0;
        end
        else
        begin
            st_reg     <= st_next;
            idx_reg    <= idx_next;
            ent_reg    <= ent_next;
            hit_reg    <= hit_next;
            lru_ok_reg <= lru_ok_next;
            lru_reg    <= lru_next;
            vrank_reg  <= vrank_next;
        end
    end

    // entries beyond the active count stay zero as in setup
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                frm_reg[i]  <= (i < 4) ? 8'(i) : 8'd0;
                rank_reg[i] <= (i < 4) ? IW'(i) : '0;
            end
        end
        else if (req.setup)
        begin
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                frm_reg[i]  <= (CW'(i) < tlb_n) ? 8'(i) : 8'd0;
                rank_reg[i] <= (CW'(i) < tlb_n) ? IW'(i) : '0;
            end
        end
        else if (st_reg == T_AGE)
        begin
            if (cur == victim)
            begin
                rank_reg[cur] <= top;
                frm_reg[cur]  <= req.frame;
            end
            else if (rank_reg[cur] > vrank_reg)
            begin
                rank_reg[cur] <= rank_reg[cur] - IW'(1);
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> st_reg == T_IDLE)
        else $error("tlb done not followed by idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_SCAN) |-> idx_reg < tlb_n)
        else $error("tlb scan index out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_AGE) |=> $stable(hit_reg))
        else $error("tlb hit changed while aging");
endmodule

// File: rtl/paged_frame_allocator_with_lru_tlb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_frame_allocator_with_lru_tlb
// frame stack allocator with per-slot page maps and an lru tlb
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// in        in   in_valid/in_stall  pfa_in_t
// out       out  out_valid/out_stall pfa_out_t
// cfg       in   cfg_we             cfg_index, cfg_data
//
// create answers after decode and, per page, a stack read then a map write;
// terminate, per page, a map read then a stack write; failures and traps
// answer from decode; access after a map read and the tlb scan and aging;
// setup answers from decode, then rewrites the frame stack one entry per
// cycle with the input stalled; reset starts the same pass over 256 entries;
// one item at a time, the next taken once idle with the result register free
// ----------------------------------------------------------------------------
module paged_frame_allocator_with_lru_tlb
    import pfa_pkg::*;
#(
    parameter int MAX_FRAMES         = MAX_FRAMES_DEF,
    parameter int MAX_SLOTS          = MAX_SLOTS_DEF,
    parameter int MAX_PAGES_PER_SLOT = MAX_PAGES_PER_SLOT_DEF,
    parameter int TLB_ENTRIES        = TLB_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  pfa_in_t    in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output pfa_out_t   out_item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [4:0] cfg_data
);
    localparam int FW  = $clog2(MAX_FRAMES);
    localparam int CNW = $clog2(MAX_FRAMES + 1);
    localparam int PW  = (MAX_PAGES_PER_SLOT > 1) ? $clog2(MAX_PAGES_PER_SLOT) : 1;
    localparam int PCW = $clog2(MAX_PAGES_PER_SLOT + 1);
    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int MAPD = MAX_SLOTS * MAX_PAGES_PER_SLOT;
    localparam int MW  = $clog2(MAPD);
    localparam int TCW = $clog2(TLB_ENTRIES + 1);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DEC    = 4'd2;
    localparam logic [3:0] S_CRD    = 4'd3;
    localparam logic [3:0] S_CWR    = 4'd4;
    localparam logic [3:0] S_TRD    = 4'd5;
    localparam logic [3:0] S_TWR    = 4'd6;
    localparam logic [3:0] S_ARD    = 4'd7;
    localparam logic [3:0] S_AWT    = 4'd8;
    localparam logic [3:0] S_ATLB   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [4:0] rpb_reg;
    logic [3:0] rfb_reg, rts_reg;
    logic [4:0] pb_reg;
    logic [CNW-1:0] nfr_reg;
    logic [TCW-1:0] tn_reg;

    logic [3:0]     st_reg;
    logic [CNW-1:0] fc_reg;
    logic [PCW-1:0] cnt_reg [MAX_SLOTS];
    logic [CNW-1:0] i_reg;
    logic [PCW-1:0] np_reg;
    pfa_in_t        it_reg;
    pfa_out_t       res_reg;
    logic           ov_reg;

    logic           sk_we, mp_we;
    logic [FW-1:0]  sk_addr, sk_wd, sk_rd;
    logic [MW-1:0]  mp_addr;
    logic [7:0]     mp_wd, mp_rd;

    pfa_tlb_req_t treq;
    pfa_tlb_rsp_t trsp;
    logic [TCW-1:0] tlb_cnt;

    // derived register values at setup
    logic [3:0] fb_c;
    logic [CNW:0] n_c;
    logic [4:0] t_c;
    always_comb
    begin
        fb_c = (rfb_reg > 4'd8) ? 4'd8 : rfb_reg;
        n_c  = (CNW+1)'(1) << fb_c;
        if (n_c > (CNW+1)'(MAX_FRAMES))
        begin
            n_c = (CNW+1)'(MAX_FRAMES);
        end
        t_c = (rts_reg == 4'd0) ? 5'd1 : {1'b0, rts_reg};
        if (t_c > 5'(TLB_ENTRIES))
        begin
            t_c = 5'(TLB_ENTRIES);
        end
        if ((CNW+1)'(t_c) > n_c)
        begin
            t_c = 5'(n_c);
        end
    end

    // create decode
    logic [31:0] mask;
    logic [31:0] rem;
    logic [32:0] pages;
    logic        slot_ok;
    logic [SW-1:0] sl;
    assign mask    = (32'd1 << pb_reg) - 32'd1;
    assign rem     = it_reg.operand_value & mask;
    assign pages   = {1'b0, it_reg.operand_value >> pb_reg} + 33'(rem != '0);
    assign slot_ok = {29'd0, it_reg.slot} < 32'(MAX_SLOTS);
    assign sl      = SW'(it_reg.slot);

    assign sk_addr = (st_reg == S_CRD || st_reg == S_CWR)
                     ? FW'(fc_reg - CNW'(1)) : FW'(st_reg == S_INIT ? i_reg : fc_reg);
    assign sk_we   = (st_reg == S_INIT) || (st_reg == S_TWR && fc_reg < CNW'(MAX_FRAMES));
    assign sk_wd   = (st_reg == S_INIT) ? FW'(i_reg) : FW'(mp_rd);
    assign mp_addr = MW'(sl) * MW'(MAX_PAGES_PER_SLOT)
                     + MW'((st_reg == S_ARD || st_reg == S_AWT || st_reg == S_ATLB)
                           ? (it_reg.operand_value >> pb_reg) : 32'(i_reg));
    assign mp_we   = (st_reg == S_CWR);
    assign mp_wd   = 8'(sk_rd);

    pfa_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_stack (
        .clk(clk), .we(sk_we), .addr(sk_addr), .wdata(sk_wd), .rdata(sk_rd));
    pfa_ram #(.WIDTH(8), .DEPTH(MAPD)) u_map (
        .clk(clk), .we(mp_we), .addr(mp_addr), .wdata(mp_wd), .rdata(mp_rd));

    assign treq.start = (st_reg == S_ATLB) && !ov_reg && (i_reg == '0);
    assign treq.setup = (st_reg == S_DEC) && (it_reg.opcode == OP_SETUP);
    assign treq.frame = mp_rd;
    assign tlb_cnt    = treq.setup ? TCW'(t_c) : tn_reg;

    pfa_tlb #(.TLB_ENTRIES(TLB_ENTRIES)) u_tlb (
        .clk(clk), .rst_n(rst_n), .tlb_n(tlb_cnt), .req(treq), .rsp(trsp));

    assign in_stall  = (st_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_item  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpb_reg <= 5'd8;
            rfb_reg <= 4'd8;
            rts_reg <= 4'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGE_BITS:  rpb_reg <= cfg_data;
                CFG_FRAME_BITS: rfb_reg <= cfg_data[3:0];
                CFG_TLB_SIZE:   rts_reg <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && in_valid && !ov_reg)
        begin
            it_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_INIT;
            pb_reg  <= 5'd8;
            nfr_reg <= CNW'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);
            tn_reg  <= TCW'((TLB_ENTRIES < 4) ? TLB_ENTRIES : 4);
            fc_reg  <= CNW'((MAX_FRAMES < 256) ? MAX_FRAMES : 256);
            i_reg   <= '0;
            np_reg  <= '0;
            ov_reg  <= 1'b0;
            res_reg <= '0;
            for (int s = 0; s < MAX_SLOTS; s++)
            begin
                cnt_reg[s] <= '0;
            end
        end
        else
        begin
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            unique case (st_reg)
                S_INIT:
                begin
                    if (i_reg == nfr_reg - CNW'(1))
                    begin
                        st_reg <= S_IDLE;
                    end
                    i_reg <= i_reg + CNW'(1);
                end
                S_IDLE:
                begin
                    i_reg <= '0;
                    if (in_valid && !ov_reg)
                    begin
                        res_reg <= '0;
                        st_reg  <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    i_reg   <= '0;
                    unique case (it_reg.opcode)
                        OP_SETUP:
                        begin
                            pb_reg  <= (rpb_reg > 5'd16) ? 5'd16 : rpb_reg;
                            nfr_reg <= CNW'(n_c);
                            tn_reg  <= TCW'(t_c);
                            fc_reg  <= CNW'(n_c);
                            for (int s = 0; s < MAX_SLOTS; s++)
                            begin
                                cnt_reg[s] <= '0;
                            end
                            res_reg.frames_free <= 9'(n_c);
                            ov_reg <= 1'b1;
                            st_reg <= S_INIT;
                        end
                        OP_CREATE:
                        begin
                            if (!slot_ok || cnt_reg[sl] != '0
                                || pages > 33'(MAX_PAGES_PER_SLOT))
                            begin
                                res_reg.status      <= ST_BUSY;
                                res_reg.frames_free <= 9'(fc_reg);
                                st_reg              <= S_DONE;
                            end
                            else if (pages > 33'(fc_reg))
                            begin
                                res_reg.status      <= ST_NOMEM;
                                res_reg.frames_free <= 9'(fc_reg);
                                st_reg              <= S_DONE;
                            end
                            else
                            begin
                                np_reg <= PCW'(pages);
                                res_reg.pages_granted <= 7'(pages);
                                res_reg.waste_bytes <= (rem != '0)
                                    ? 16'(mask + 32'd1 - rem) : 16'd0;
                                cnt_reg[sl] <= PCW'(pages);
                                st_reg <= (pages == '0) ? S_DONE : S_CRD;
                                res_reg.frames_free <= 9'(fc_reg);
                            end
                        end
                        OP_TERM:
                        begin
                            res_reg.frames_free <= 9'(fc_reg);
                            if (slot_ok && cnt_reg[sl] != '0)
                            begin
                                np_reg <= cnt_reg[sl];
                                cnt_reg[sl] <= '0;
                                st_reg <= S_TRD;
                            end
                            else
                            begin
                                st_reg <= S_DONE;
                            end
                        end
                        OP_ACCESS:
                        begin
                            res_reg.frames_free <= 9'(fc_reg);
                            if (!slot_ok
                                || (it_reg.operand_value >> pb_reg) >= 32'(cnt_reg[sl]))
                            begin
                                res_reg.status <= ST_TRAP;
                                st_reg         <= S_DONE;
                            end
                            else
                            begin
                                st_reg <= S_ARD;
                            end
                        end
                        default: st_reg <= S_DONE;
                    endcase
                end
                S_CRD:
                begin
                    st_reg <= S_CWR;
                end
                S_CWR:
                begin
                    fc_reg <= fc_reg - CNW'(1);
                    i_reg  <= i_reg + CNW'(1);
                    if (i_reg == CNW'(np_reg) - CNW'(1))
                    begin
                        res_reg.frames_free <= 9'(fc_reg - CNW'(1));
                        st_reg <= S_DONE;
                    end
                    else
                    begin
                        st_reg <= S_CRD;
                    end
                end
                S_TRD:
                begin
                    st_reg <= S_TWR;
                end
                S_TWR:
                begin
                    if (fc_reg < CNW'(MAX_FRAMES))
                    begin
                        fc_reg <= fc_reg + CNW'(1);
                    end
                    i_reg <= i_reg + CNW'(1);
                    if (i_reg == CNW'(np_reg) - CNW'(1))
                    begin
                        res_reg.frames_free <= 9'((fc_reg < CNW'(MAX_FRAMES))
                                                  ? fc_reg + CNW'(1) : fc_reg);
                        st_reg <= S_DONE;
                    end
                    else
                    begin
                        st_reg <= S_TRD;
                    end
                end
                S_ARD:
                begin
                    st_reg <= S_AWT;
                end
                S_AWT:
                begin
                    st_reg <= S_ATLB;
                end
                S_ATLB:
                begin
                    i_reg <= CNW'(1);
                    if (trsp.done)
                    begin
                        res_reg.tlb_hit      <= trsp.hit;
                        res_reg.frame_number <= mp_rd;
                        res_reg.page_offset  <= 16'(it_reg.operand_value & mask);
                        st_reg               <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    ov_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> in_stall)
        else $error("item taken while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= CNW'(MAX_FRAMES))
        else $error("free count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DONE) |=> ov_reg)
        else $error("result not presented");
endmodule

// File: verif/paged_frame_allocator_with_lru_tlb_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_frame_allocator_with_lru_tlb_test
// checks the frame allocator and its lru tlb, item by item, against a
// behavioral copy of the block kept in this module; a directed table runs
// first, then random setup, create, access and terminate traffic under random
// sender gaps, receiver stalls and one long receiver hold-off
// ----------------------------------------------------------------------------
module paged_frame_allocator_with_lru_tlb_test;
    import pfa_pkg::*;

    localparam int NFR = 256;
    localparam int NSL = 8;
    localparam int NPG = 64;
    localparam int NTLB = 8;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        pfa_in_t  item;
        logic     checked;
        pfa_out_t result;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    pfa_in_t    in_item = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    pfa_out_t   out_item;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_PAGE_BITS;
    logic [4:0] cfg_data = '0;

    // register shadows and latched settings
    int reg_pb = 8, reg_fb = 8, reg_ts = 4;
    int act_pb, act_frames, act_tlb;
    int frame_stack [NFR];
    int frames_left;
    int slot_map [NSL*NPG];
    int slot_pages [NSL];
    int tlb_frame [NTLB];
    int tlb_rank [NTLB];

    pfa_out_t expected_q [$];
    row_t     rows [$];
    int  row_idx = 0;
    int  errors = 0;
    int  cycles = 0;
    int  hold_cycles = 0;

    paged_frame_allocator_with_lru_tlb u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void rebuild_memory();
        int fb;
        fb = reg_fb > 8 ? 8 : reg_fb;
        act_frames = 1 << fb;
        act_pb = reg_pb > 16 ? 16 : reg_pb;
        act_tlb = reg_ts < 1 ? 1 : reg_ts;
        if (act_tlb > NTLB)
            act_tlb = NTLB;
        if (act_tlb > act_frames)
            act_tlb = act_frames;
        for (int i = 0; i < NFR; i++)
            frame_stack[i] = i < act_frames ? i : 0;
        frames_left = act_frames;
        for (int i = 0; i < NSL*NPG; i++)
            slot_map[i] = 0;
        for (int i = 0; i < NSL; i++)
            slot_pages[i] = 0;
        for (int i = 0; i < NTLB; i++)
        begin
            tlb_frame[i] = i < act_tlb ? i : 0;
            tlb_rank[i] = i < act_tlb ? i : 0;
        end
    endfunction

    function automatic pfa_out_t translate_item(pfa_in_t it);
        pfa_out_t r;
        longint mask, rem, pages, page;
        int f, e, rk;
        r = '0;
        mask = (64'd1 << act_pb) - 1;
        case (it.opcode)
            OP_SETUP:
                rebuild_memory();
            OP_CREATE:
            begin
                rem = it.operand_value & mask;
                pages = (it.operand_value >> act_pb) + (rem != 0);
                if (slot_pages[it.slot] != 0 || pages > NPG)
                    r.status = ST_BUSY;
                else if (pages > frames_left)
                    r.status = ST_NOMEM;
                else
                begin
                    for (int i = 0; i < pages; i++)
                    begin
                        frames_left--;
                        slot_map[it.slot*NPG + i] = frame_stack[frames_left];
                    end
                    slot_pages[it.slot] = int'(pages);
                    r.pages_granted = 7'(pages);
                    r.waste_bytes = rem != 0 ? 16'(mask + 1 - rem) : 16'd0;
                end
            end
            OP_TERM:
            begin
                for (int i = 0; i < slot_pages[it.slot]; i++)
                    if (frames_left < NFR)
                        frame_stack[frames_left++] = slot_map[it.slot*NPG + i];
                slot_pages[it.slot] = 0;
            end
            default:
            begin
                page = it.operand_value >> act_pb;
                if (page >= slot_pages[it.slot])
                    r.status = ST_TRAP;
                else
                begin
                    f = slot_map[it.slot*NPG + page];
                    e = act_tlb;
                    for (int i = act_tlb - 1; i >= 0; i--)
                        if (tlb_frame[i] == f)
                            e = i;
                    if (e < act_tlb)
                        r.tlb_hit = 1'b1;
                    else
                    begin
                        e = 0;
                        for (int i = act_tlb - 1; i >= 0; i--)
                            if (tlb_rank[i] == 0)
                                e = i;
                        tlb_frame[e] = f;
                    end
                    rk = tlb_rank[e];
                    for (int i = 0; i < act_tlb; i++)
                        if (tlb_rank[i] > rk)
                            tlb_rank[i]--;
                    tlb_rank[e] = act_tlb - 1;
                    r.frame_number = 8'(f);
                    r.page_offset = 16'(it.operand_value & mask);
                end
            end
        endcase
        r.frames_free = 9'(frames_left);
        return r;
    endfunction

    function automatic void add_row(pfa_in_t it, logic chk, pfa_out_t res);
        row_t rw;
        rw.item = it;
        rw.checked = chk;
        rw.result = res;
        rows.insert(rows.size(), rw);
    endfunction

    // in-flight items get their prediction when accepted
    always @(posedge clk)
    begin
        pfa_out_t pred;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            pred = translate_item(in_item);
            if (row_idx < rows.size())
            begin
                if (rows[row_idx].checked)
                    pred = rows[row_idx].result;
                row_idx++;
            end
            expected_q.insert(expected_q.size(), pred);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, out_item);
                errors++;
            end
            else
            begin
                pfa_out_t ex;
                ex = expected_q.pop_front();
                if (ex !== out_item)
                begin
                    $display("%0t mismatch expected %p actual %p", $time, ex, out_item);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    initial
    begin
        int mode;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_stall <= 1'b1;
            end
            else
            begin
                mode = (cycles / 2000) % 3;
                if (mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    task automatic send_item(pfa_in_t it);
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain_and_wait();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[4:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PAGE_BITS)
            reg_pb = val & 31;
        else if (idx == CFG_FRAME_BITS)
            reg_fb = val & 15;
        else
            reg_ts = val & 15;
    endtask

    function automatic pfa_in_t mk(logic [1:0] op, int sl, logic [31:0] v);
        pfa_in_t it;
        it.opcode = op;
        it.slot = sl[2:0];
        it.operand_value = v;
        return it;
    endfunction

    function automatic pfa_in_t random_item();
        int k, sl;
        logic [31:0] v;
        k = $urandom_range(0, 99);
        sl = $urandom_range(0, 7);
        if (k < 2)
            return mk(OP_SETUP, sl, $urandom());
        if (k < 30)
        begin
            if ($urandom_range(0, 9) == 0)
                v = $urandom();
            else
                v = $urandom_range(0, 12 << act_pb);
            return mk(OP_CREATE, sl, v);
        end
        if (k < 42)
            return mk(OP_TERM, sl, $urandom());
        if (slot_pages[sl] != 0 && $urandom_range(0, 9) != 0)
            v = ($urandom_range(0, slot_pages[sl] - 1) << act_pb)
                | ($urandom() & ((1 << act_pb) - 1));
        else
            v = $urandom();
        return mk(OP_ACCESS, sl, v);
    endfunction

    initial
    begin
        int settings [5][3];
        pfa_out_t r0;
        settings = '{'{8, 8, 4}, '{0, 0, 1}, '{16, 8, 8}, '{31, 15, 15}, '{4, 3, 0}};
        rebuild_memory();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        r0 = '0; r0.frames_free = 9'd256;
        add_row(mk(OP_ACCESS, 0, 32'h0), 1'b1,
                '{ST_TRAP, 1'b0, 8'd0, 16'd0, 7'd0, 16'd0, 9'd256});
        add_row(mk(OP_TERM, 7, 32'hFFFFFFFF), 1'b1, r0);
        add_row(mk(OP_CREATE, 0, 32'h0), 1'b1, r0);
        add_row(mk(OP_CREATE, 1, 32'hFFFFFFFF), 1'b1,
                '{ST_BUSY, 1'b0, 8'd0, 16'd0, 7'd0, 16'd0, 9'd256});
        add_row(mk(OP_CREATE, 2, 32'd16385), 1'b1,
                '{ST_BUSY, 1'b0, 8'd0, 16'd0, 7'd0, 16'd0, 9'd256});
        add_row(mk(OP_CREATE, 2, 32'd16384), 1'b1,
                '{ST_OK, 1'b0, 8'd0, 16'd0, 7'd64, 16'd0, 9'd192});
        add_row(mk(OP_CREATE, 2, 32'd1), 1'b1,
                '{ST_BUSY, 1'b0, 8'd0, 16'd0, 7'd0, 16'd0, 9'd192});
        add_row(mk(OP_CREATE, 3, 32'd257), 1'b0, r0);
        add_row(mk(OP_ACCESS, 2, 32'h00003FFF), 1'b0, r0);
        add_row(mk(OP_ACCESS, 2, 32'h00003F00), 1'b0, r0);
        add_row(mk(OP_ACCESS, 2, 32'h00000000), 1'b0, r0);
        add_row(mk(OP_ACCESS, 2, 32'h00004000), 1'b0, r0);
        add_row(mk(OP_ACCESS, 3, 32'h000001AB), 1'b0, r0);
        add_row(mk(OP_ACCESS, 3, 32'h00000055), 1'b0, r0);
        add_row(mk(OP_CREATE, 4, 32'd16384), 1'b0, r0);
        add_row(mk(OP_CREATE, 5, 32'd16384), 1'b0, r0);
        add_row(mk(OP_CREATE, 6, 32'd16384), 1'b0, r0);
        add_row(mk(OP_TERM, 3, 32'h0), 1'b0, r0);
        add_row(mk(OP_TERM, 3, 32'h0), 1'b0, r0);
        add_row(mk(OP_ACCESS, 3, 32'h0), 1'b0, r0);
        add_row(mk(OP_TERM, 2, 32'h0), 1'b0, r0);
        add_row(mk(OP_SETUP, 0, 32'h0), 1'b1, r0);

        foreach (rows[i])
        begin
            send_item(rows[i].item);
        end
        in_valid <= 1'b0;
        drain_and_wait();

        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_PAGE_BITS, settings[p][0]);
            write_reg(CFG_FRAME_BITS, settings[p][1]);
            write_reg(CFG_TLB_SIZE, settings[p][2]);
            send_item(mk(OP_SETUP, $urandom_range(0, 7), $urandom()));
            for (int n = 0; n < RANDOM_ITEMS / 5; n++)
            begin
                if (p == 2 && n == 50)
                    hold_cycles = 3000;
                send_item(random_item());
                idle_gap();
            end
            drain_and_wait();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
